@@ rtl/rptvm_pkg.sv @@
package rptvm_pkg;

    localparam int GRID_SIZE       = 64;
    localparam int COORD_FRAC_BITS = 12;
    localparam int PROD_FRAC       = 16 + COORD_FRAC_BITS;
    localparam int VOXELS          = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W          = $clog2(VOXELS);
    localparam int COORD_W         = $clog2(GRID_SIZE);

    localparam int PIX_W    = 19;
    localparam int COEF_W   = 18;
    localparam int ROW_W    = 3 * COEF_W;
    localparam int SA_W     = 24;
    localparam int INT_W    = 16;
    localparam int IDX_W    = 18;
    localparam int SUM_W    = 64;
    localparam int WEIGHT_W = 40;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = FRAC_W + 1;
    localparam int Q_W      = INT_W + 32;
    localparam int Q_LO_W   = 24;
    localparam int Q_HI_W   = Q_W - Q_LO_W;
    localparam int PART_W   = TERM_W + Q_LO_W;

    localparam int ACC_W    = 48;
    localparam int IP_W     = ACC_W - PROD_FRAC;

    localparam int MUL_A_W  = 36;
    localparam int MUL_B_W  = 26;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;

    localparam logic [ACC_W-1:0] CENTRE =
        ACC_W'(GRID_SIZE - 1) << (PROD_FRAC - 1);

    localparam logic [1:0] REG_ROW_X = 2'd0;
    localparam logic [1:0] REG_ROW_Y = 2'd1;
    localparam logic [1:0] REG_ROW_Z = 2'd2;

    localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(65536);
    localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(65536) << COEF_W;
    localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(65536) << (2 * COEF_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_ROT_MUL,
        ST_ROT_ACC,
        ST_ROT_CHK,
        ST_DIV_WAIT,
        ST_W_P1,
        ST_W_P2,
        ST_W_RND,
        ST_W_QLO,
        ST_W_QHI,
        ST_W_WR
    } t_state;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SUM_W-1:0]    sum;
        logic [WEIGHT_W-1:0] weight;
    } t_store_wr;

endpackage

@@ rtl/rptvm_mul.sv @@
module rptvm_mul
    import rptvm_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ rtl/rptvm_div.sv @@
module rptvm_div
    import rptvm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [INT_W-1:0] i_intensity,
    input  logic [SA_W-1:0] i_solid_angle,
    output logic            o_done,
    output logic [Q_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SA_W:0]    r_rem, n_rem;
    logic [Q_W-1:0]   r_quo, n_quo;
    logic [SA_W-1:0]  r_den, n_den;
    logic [SA_W:0]    rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        rem_sh = {r_rem[SA_W-1:0], r_quo[Q_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = {i_intensity, 32'd0};
            n_den  = (i_solid_angle == '0) ? SA_W'(1) : i_solid_angle;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sh - {1'b0, r_den};
                n_quo = {r_quo[Q_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[Q_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(Q_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_quo;

endmodule

@@ rtl/rptvm_store.sv @@
module rptvm_store
    import rptvm_pkg::*;
(
    input  logic                i_clk,
    input  t_store_wr           i_wr,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [SUM_W-1:0]    o_rd_sum,
    output logic [WEIGHT_W-1:0] o_rd_weight
);

    logic [SUM_W-1:0]    sum_mem    [VOXELS];
    logic [WEIGHT_W-1:0] weight_mem [VOXELS];
    logic [SUM_W-1:0]    r_rd_sum;
    logic [WEIGHT_W-1:0] r_rd_weight;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            sum_mem[i_wr.addr]    <= i_wr.sum;
            weight_mem[i_wr.addr] <= i_wr.weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_sum    <= sum_mem[i_rd_addr];
            r_rd_weight <= weight_mem[i_rd_addr];
        end
    end

    assign o_rd_sum    = r_rd_sum;
    assign o_rd_weight = r_rd_weight;

endmodule

@@ rtl/rotated_pixel_trilinear_volume_merge_unit.sv @@
// Channel   | Signals                                           | Handshake
// ----------+---------------------------------------------------+------------------------
// item in   | i_operation, i_pixel_*, i_solid_angle, ...        | start high, busy low
// result    | o_in_range, o_voxel_sum, o_voxel_weight           | o_valid, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata      | APB, pready tied high
//
// A read beat passes through ST_RD_ADDR and ST_RD_DATA. In a merge beat the serial divider
// runs alongside the rotation, then eight corners share the one multiplier and the one
// read port of the stores; with zero intensity a corner skips the two quotient products.
// An out-of-range pixel ends at the range check of the first axis that falls outside.
// After reset both stores are cleared, one voxel a cycle, through all GRID_SIZE^3 voxels
// (262144), and busy stays high meanwhile. Results cannot be held off by the receiver.
module rotated_pixel_trilinear_volume_merge_unit
    import rptvm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic signed [PIX_W-1:0]    i_pixel_x,
    input  logic signed [PIX_W-1:0]    i_pixel_y,
    input  logic signed [PIX_W-1:0]    i_pixel_z,
    input  logic [SA_W-1:0]            i_solid_angle,
    input  logic [INT_W-1:0]           i_intensity,
    input  logic [IDX_W-1:0]           i_voxel_index,
    output logic                       o_valid,
    output logic                       o_in_range,
    output logic [SUM_W-1:0]           o_voxel_sum,
    output logic [WEIGHT_W-1:0]        o_voxel_weight,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_clr, n_clr;
    logic [ROW_W-1:0]          r_row [3];
    logic [ROW_W-1:0]          n_row [3];
    logic signed [PIX_W-1:0]   r_pix_x, r_pix_y, r_pix_z, n_pix_x, n_pix_y, n_pix_z;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_add_sum, n_add_sum;
    logic [1:0]                r_axis, n_axis;
    logic [1:0]                r_term, n_term;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [COORD_W-1:0]        r_base [3];
    logic [COORD_W-1:0]        n_base [3];
    logic [FRAC_W-1:0]         r_fr [3];
    logic [FRAC_W-1:0]         n_fr [3];
    logic [2:0]                r_corner, n_corner;
    logic [TERM_W-1:0]         r_w, n_w;
    logic [PART_W-1:0]         r_plo, n_plo;
    logic                      r_o_valid, n_o_valid;
    logic                      r_o_in_range, n_o_in_range;
    logic [SUM_W-1:0]          r_o_sum, n_o_sum;
    logic [WEIGHT_W-1:0]       r_o_weight, n_o_weight;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic [Q_W-1:0]            div_q;
    t_store_wr                 st_wr;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [SUM_W-1:0]          rd_sum;
    logic [WEIGHT_W-1:0]       rd_weight;

    logic                      cfg_wr;
    logic signed [PIX_W-1:0]   pix_sel;
    logic [ROW_W-1:0]          row_sel;
    logic signed [COEF_W-1:0]  coef_sel;
    logic [IP_W-1:0]           ip;
    logic                      axis_ok;
    logic [COORD_W-1:0]        bx, by, bz;
    logic [ADDR_W-1:0]         corner_addr;
    logic [TERM_W-1:0]         tx, ty, tz;
    logic [49:0]               rnd;
    logic [PART_W+25:0]        wq;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          new_sum;
    logic [WEIGHT_W:0]         wt_add;
    logic [WEIGHT_W-1:0]       new_weight;
    logic                      idx_ok;

    rptvm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rptvm_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (div_start),
        .i_intensity   (i_intensity),
        .i_solid_angle (i_solid_angle),
        .o_done        (div_done),
        .o_quotient    (div_q)
    );

    rptvm_store u_store (
        .i_clk       (i_clk),
        .i_wr        (st_wr),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_sum    (rd_sum),
        .o_rd_weight (rd_weight)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_row[0]  <= ROW_X_RST;
            r_row[1]  <= ROW_Y_RST;
            r_row[2]  <= ROW_Z_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
        end
        r_pix_x      <= n_pix_x;
        r_pix_y      <= n_pix_y;
        r_pix_z      <= n_pix_z;
        r_idx        <= n_idx;
        r_add_sum    <= n_add_sum;
        r_axis       <= n_axis;
        r_term       <= n_term;
        r_acc        <= n_acc;
        r_base       <= n_base;
        r_fr         <= n_fr;
        r_corner     <= n_corner;
        r_w          <= n_w;
        r_plo        <= n_plo;
        r_o_in_range <= n_o_in_range;
        r_o_sum      <= n_o_sum;
        r_o_weight   <= n_o_weight;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_row = r_row;
        if (cfg_wr) begin
            case (paddr[4:3])
                REG_ROW_X: n_row[0] = pwdata[ROW_W-1:0];
                REG_ROW_Y: n_row[1] = pwdata[ROW_W-1:0];
                REG_ROW_Z: n_row[2] = pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ROW_X: prdata = PDATA_W'(r_row[0]);
            REG_ROW_Y: prdata = PDATA_W'(r_row[1]);
            REG_ROW_Z: prdata = PDATA_W'(r_row[2]);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb begin
        case (r_term)
            2'd0:    pix_sel = r_pix_x;
            2'd1:    pix_sel = r_pix_y;
            default: pix_sel = r_pix_z;
        endcase
        case (r_axis)
            2'd0:    row_sel = r_row[0];
            2'd1:    row_sel = r_row[1];
            default: row_sel = r_row[2];
        endcase
        case (r_term)
            2'd0:    coef_sel = row_sel[COEF_W-1:0];
            2'd1:    coef_sel = row_sel[2*COEF_W-1:COEF_W];
            default: coef_sel = row_sel[3*COEF_W-1:2*COEF_W];
        endcase
    end

    assign ip      = r_acc[ACC_W-1:PROD_FRAC];
    assign axis_ok = !r_acc[ACC_W-1] && (ip >= IP_W'(1)) && (ip <= IP_W'(GRID_SIZE - 2));

    assign bx = r_base[0] + COORD_W'(r_corner[2]);
    assign by = r_base[1] + COORD_W'(r_corner[1]);
    assign bz = r_base[2] + COORD_W'(r_corner[0]);
    assign corner_addr = (ADDR_W'(bx) * ADDR_W'(GRID_SIZE) + ADDR_W'(by))
                         * ADDR_W'(GRID_SIZE) + ADDR_W'(bz);

    assign tx = r_corner[2] ? {1'b0, r_fr[0]} : TERM_W'(65536) - {1'b0, r_fr[0]};
    assign ty = r_corner[1] ? {1'b0, r_fr[1]} : TERM_W'(65536) - {1'b0, r_fr[1]};
    assign tz = r_corner[0] ? {1'b0, r_fr[2]} : TERM_W'(65536) - {1'b0, r_fr[2]};

    assign rnd = mul_p[49:0] + 50'(64'd1 << 31);

    assign wq      = (PART_W+26)'(r_plo) + ((PART_W+26)'(mul_p[PART_W-1:0]) << Q_LO_W);
    assign sum_add = (SUM_W+1)'(rd_sum) + (SUM_W+1)'(wq[PART_W+25:8]);
    assign new_sum = !r_add_sum ? rd_sum :
                     (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]);
    assign wt_add  = (WEIGHT_W+1)'(rd_weight) + (WEIGHT_W+1)'(r_w);
    assign new_weight = wt_add[WEIGHT_W] ? {WEIGHT_W{1'b1}} : wt_add[WEIGHT_W-1:0];

    assign idx_ok    = (32'(r_idx) < 32'(VOXELS));
    assign div_start = (r_state == ST_IDLE) && start && !i_operation;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pix_x      = r_pix_x;
        n_pix_y      = r_pix_y;
        n_pix_z      = r_pix_z;
        n_idx        = r_idx;
        n_add_sum    = r_add_sum;
        n_axis       = r_axis;
        n_term       = r_term;
        n_acc        = r_acc;
        n_base       = r_base;
        n_fr         = r_fr;
        n_corner     = r_corner;
        n_w          = r_w;
        n_plo        = r_plo;
        n_o_valid    = 1'b0;
        n_o_in_range = r_o_in_range;
        n_o_sum      = r_o_sum;
        n_o_weight   = r_o_weight;
        mul_a        = '0;
        mul_b        = '0;
        st_wr        = '0;
        rd_en        = 1'b0;
        rd_addr      = corner_addr;
        case (r_state)
            ST_CLEAR: begin
                st_wr.we   = 1'b1;
                st_wr.addr = r_clr;
                n_clr      = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(VOXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_pix_x   = i_pixel_x;
                    n_pix_y   = i_pixel_y;
                    n_pix_z   = i_pixel_z;
                    n_idx     = i_voxel_index;
                    n_add_sum = (i_intensity != '0);
                    n_axis    = 2'd0;
                    n_term    = 2'd0;
                    n_acc     = CENTRE;
                    n_state   = i_operation ? ST_RD_ADDR : ST_ROT_MUL;
                end
            end
            ST_RD_ADDR: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(r_idx);
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_o_valid    = 1'b1;
                n_o_in_range = 1'b1;
                n_o_sum      = idx_ok ? rd_sum : '0;
                n_o_weight   = idx_ok ? rd_weight : '0;
                n_state      = ST_IDLE;
            end
            ST_ROT_MUL: begin
                mul_a   = MUL_A_W'(pix_sel);
                mul_b   = MUL_B_W'(coef_sel);
                n_state = ST_ROT_ACC;
            end
            ST_ROT_ACC: begin
                n_acc = r_acc + mul_p[ACC_W-1:0];
                if (r_term == 2'd2) begin
                    n_state = ST_ROT_CHK;
                end else begin
                    n_term  = r_term + 2'd1;
                    n_state = ST_ROT_MUL;
                end
            end
            ST_ROT_CHK: begin
                if (!axis_ok) begin
                    n_o_valid    = 1'b1;
                    n_o_in_range = 1'b0;
                    n_o_sum      = '0;
                    n_o_weight   = '0;
                    n_state      = ST_IDLE;
                end else begin
                    n_base[r_axis] = ip[COORD_W-1:0];
                    n_fr[r_axis]   = r_acc[COORD_FRAC_BITS+FRAC_W-1:COORD_FRAC_BITS];
                    n_term         = 2'd0;
                    n_acc          = CENTRE;
                    n_axis         = r_axis + 2'd1;
                    n_corner       = '0;
                    n_state        = (r_axis == 2'd2) ? ST_DIV_WAIT : ST_ROT_MUL;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_W_P1;
                end
            end
            ST_W_P1: begin
                mul_a   = MUL_A_W'(tx);
                mul_b   = MUL_B_W'(ty);
                rd_en   = 1'b1;
                n_state = ST_W_P2;
            end
            ST_W_P2: begin
                mul_a   = MUL_A_W'(mul_p[33:0]);
                mul_b   = MUL_B_W'(tz);
                n_state = ST_W_RND;
            end
            ST_W_RND: begin
                n_w     = rnd[48:32];
                n_state = r_add_sum ? ST_W_QLO : ST_W_WR;
            end
            ST_W_QLO: begin
                mul_a   = MUL_A_W'(r_w);
                mul_b   = MUL_B_W'(div_q[Q_LO_W-1:0]);
                n_state = ST_W_QHI;
            end
            ST_W_QHI: begin
                n_plo   = mul_p[PART_W-1:0];
                mul_a   = MUL_A_W'(r_w);
                mul_b   = MUL_B_W'(div_q[Q_W-1:Q_LO_W]);
                n_state = ST_W_WR;
            end
            ST_W_WR: begin
                st_wr.we     = 1'b1;
                st_wr.addr   = corner_addr;
                st_wr.sum    = new_sum;
                st_wr.weight = new_weight;
                n_corner     = r_corner + 3'd1;
                if (r_corner == 3'd7) begin
                    n_o_valid    = 1'b1;
                    n_o_in_range = 1'b1;
                    n_o_sum      = '0;
                    n_o_weight   = '0;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_W_P1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_in_range     = r_o_in_range;
    assign o_voxel_sum    = r_o_sum;
    assign o_voxel_weight = r_o_weight;

    a_valid_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_IDLE))
        else $error("result beat shown while the sequencer is not idle");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_RD_DATA || $past(r_state) == ST_ROT_CHK ||
                     $past(r_state) == ST_W_WR))
        else $error("result beat without a finishing step");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_quotient_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W_QLO) |-> div_done)
        else $error("sum update used an unfinished quotient");

endmodule
